### hw/rtl/mlef_pkg.sv
package mlef_pkg;

    localparam int SMP_W  = 16;
    localparam int CODE_W = 8;
    localparam int ERR_W  = 12;
    localparam int MAG_W  = 15;

    localparam logic [MAG_W-1:0]  MU_BIAS = 15'd132;
    localparam logic [MAG_W-1:0]  MU_CLIP = 15'd32767;

    // Code whose expansion is minus one rather than zero.
    localparam logic [CODE_W-1:0] CODE_NEG_ONE = 8'h7f;

    typedef logic signed [SMP_W-1:0]  sample_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic        [CODE_W-1:0] code_t;

    // Expand a mu-law byte back to a linear sample.
    function automatic sample_t mu_decode(input code_t code);
        logic [CODE_W-1:0] u;
        logic [2:0]        e;
        logic [3:0]        m;
        logic [MAG_W-1:0]  base;
        logic [MAG_W-1:0]  mag;
        u    = ~code;
        e    = u[6:4];
        m    = u[3:0];
        base = MAG_W'({m, 3'b000}) + MU_BIAS;
        mag  = (base << e) - MU_BIAS;
        if (code == CODE_NEG_ONE)
        begin
            return -16'sd1;
        end
        else if (u[7])
        begin
            return sample_t'(-$signed({1'b0, mag}));
        end
        else
        begin
            return sample_t'($signed({1'b0, mag}));
        end
    endfunction

endpackage

### hw/rtl/mlef_quant.sv
module mlef_quant
    import mlef_pkg::*;
(
    input  sample_t sample,
    input  logic    first_sample,
    input  err_t    err_in,
    output code_t   code,
    output err_t    err_out
);

    err_t                 err_eff;
    logic signed [16:0]   sum_full;
    sample_t              sum;
    logic                 neg;
    logic        [16:0]   mag;
    logic        [16:0]   adj_full;
    logic [MAG_W-1:0]     adj;
    logic        [2:0]    expo;
    logic        [3:0]    mant;
    sample_t              dec;
    logic signed [16:0]   err_full;

    always_comb
    begin
        err_eff  = first_sample ? '0 : err_in;
        sum_full = 17'(sample) + 17'(err_eff);
        if (sum_full > 17'sd32767)
        begin
            sum = 16'sh7fff;
        end
        else if (sum_full < -17'sd32768)
        begin
            sum = 16'sh8000;
        end
        else
        begin
            sum = sum_full[15:0];
        end

        neg      = sum[15];
        mag      = neg ? (17'd0 - 17'($unsigned({sum[15], sum}))) : {1'b0, sum};
        adj_full = mag + 17'(MU_BIAS);
        adj      = (adj_full > 17'(MU_CLIP)) ? MU_CLIP : adj_full[MAG_W-1:0];

        // exponent from the highest set bit above bit 7
        if (adj[14])      expo = 3'd7;
        else if (adj[13]) expo = 3'd6;
        else if (adj[12]) expo = 3'd5;
        else if (adj[11]) expo = 3'd4;
        else if (adj[10]) expo = 3'd3;
        else if (adj[9])  expo = 3'd2;
        else if (adj[8])  expo = 3'd1;
        else              expo = 3'd0;

        mant = 4'(adj >> ({1'b0, expo} + 4'd3));
        code = ~{neg, expo, mant};

        dec      = mu_decode(code);
        err_full = 17'(sum) - 17'(dec);
        if (err_full > 17'sd2047)
        begin
            err_out = 12'sh7ff;
        end
        else if (err_full < -17'sd2048)
        begin
            err_out = 12'sh800;
        end
        else
        begin
            err_out = err_full[ERR_W-1:0];
        end
    end

endmodule

### hw/rtl/mulaw_error_feedback_encoder_core.sv
// mu-law encoder with quantisation error feedback. Each input item carries a
// signed 16-bit sample (tdata) and a first-sample flag (tuser) that clears the
// carried error before that sample. The sample plus the carried error is
// saturated, mu-law encoded with standard polarity (codes 128..255 for
// non-negative values), decoded again, and the difference is kept as the
// next carried error. One item is taken per cycle unless back-pressure
// holds the flow: the input register takes the item at the accepting edge,
// and the result register then puts its code on m_tdata once that slot is free.
// The throughput of one item per cycle is set by the error loop, which
// closes combinationally through the add, encode, decode and subtract
// logic. Back-pressure on the master side stalls both stages; an item
// already held is never dropped.
module mulaw_error_feedback_encoder_core
    import mlef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // [0] first_sample

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] code
);

    logic    in_valid_reg;
    sample_t in_sample_reg;
    logic    in_first_reg;
    logic    out_valid_reg;
    code_t   out_code_reg;
    err_t    err_reg;

    code_t   code_next;
    err_t    err_next;
    logic    advance;

    // Move the held item into the result register when that slot is free
    // or is being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mlef_quant u_quant (
        .sample       (in_sample_reg),
        .first_sample (in_first_reg),
        .err_in       (err_reg),
        .code         (code_next),
        .err_out      (err_next)
    );

    // Hold the input item until it can advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_sample_reg <= s_tdata;
            in_first_reg  <= s_tuser;
        end
    end

    // Result register and carried error advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            err_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                err_reg       <= err_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= code_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;

    // The carried error never leaves the range one quantisation step allows.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg >= -12'sd644) && (err_reg <= 12'sd643))
        else $error("carried error out of range");

    // The error register changes only when an item advances.
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(err_reg))
        else $error("carried error changed without an item");

    // Input is refused only when both stages are full and the output stalls.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input refused with room in the pipeline");

endmodule

### tb/mulaw_error_feedback_encoder_checker.sv
// Watches both item channels of the encoder. Predicts each code from the
// accepted samples and compares it with the code that leaves the block.
module mulaw_code_checker
    import mlef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          mismatches,
    output int          codes_waiting
);

    err_t  carried_err;
    code_t codes_due[$];
    code_t want;
    int    lin_sum;
    int    resid;

    function automatic code_t mulaw_compress(input int lin);
        logic neg;
        int   mag;
        int   adj;
        int   hi;
        int   expo;
        int   mant;
        neg  = (lin < 0);
        mag  = neg ? -lin : lin;
        adj  = mag + int'(MU_BIAS);
        if (adj > int'(MU_CLIP))
        begin
            adj = int'(MU_CLIP);
        end
        hi   = (adj >> 7) & 8'hff;
        expo = 0;
        while (hi > 1)
        begin
            hi   = hi >> 1;
            expo = expo + 1;
        end
        mant = (adj >> (expo + 3)) & 4'hf;
        return ~{neg, expo[2:0], mant[3:0]};
    endfunction

    function automatic int mulaw_expand(input code_t c);
        code_t u;
        int    mag;
        u   = ~c;
        mag = (((int'(u[3:0]) << 3) + int'(MU_BIAS)) << u[6:4]) - int'(MU_BIAS);
        if (c == CODE_NEG_ONE)
        begin
            return -1;
        end
        return u[7] ? -mag : mag;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carried_err = '0;
            codes_due.delete();
            mismatches    <= 0;
            codes_waiting <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (codes_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected code %0d, none predicted", m_tdata);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = codes_due.pop_front();
                    if (m_tdata !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("code mismatch: expected %0d got %0d", want, m_tdata);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                // new sound: forget the error left by the previous one
                if (s_tuser)
                begin
                    carried_err = '0;
                end
                lin_sum = int'($signed(s_tdata)) + int'(carried_err);
                if (lin_sum > 32767)
                begin
                    lin_sum = 32767;
                end
                else if (lin_sum < -32768)
                begin
                    lin_sum = -32768;
                end
                want  = mulaw_compress(lin_sum);
                resid = lin_sum - mulaw_expand(want);
                if (resid > 2047)
                begin
                    resid = 2047;
                end
                else if (resid < -2048)
                begin
                    resid = -2048;
                end
                carried_err = err_t'(resid);
                codes_due.push_back(want);
            end
            codes_waiting <= codes_due.size();
        end
    end

endmodule

### tb/mulaw_error_feedback_encoder_core_tb.sv
// Stimulus and verdict for the mu-law encoder with error feedback. The
// checker beside the block does all prediction and comparison; this module
// only feeds samples, throttles the output side and reports the outcome.
module mulaw_error_feedback_encoder_core_tb;
    import mlef_pkg::*;

    localparam int SAMPLE_TARGET = 1650;
    localparam int LONG_HOLD     = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] sample
    logic        s_tuser;   // [0] first_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] code

    int   mismatches;
    int   codes_waiting;
    int   samples_sent;
    bit   idle_on;          // random gaps on both sides while set
    bit   hold_request;     // ask the output side for one long hold-off
    bit   hold_done;        // the long hold-off has been asked for
    int   hold_left;
    int   stall_left;

    mulaw_error_feedback_encoder_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mulaw_code_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .codes_waiting (codes_waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Hold reset from time zero, release it on a falling edge, never again.
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        idle_on      = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        samples_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 92)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one item from a falling edge, after a random gap when idling, and hold it
    // until accepted; return on the next falling edge so the next item can be driven.
    task automatic offer_sample(input sample_t smp, input logic first);
        int gap;
        gap = 0;
        if (idle_on && ($urandom_range(0, 99) < 35))
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= first;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        samples_sent = samples_sent + 1;
        @(negedge clk);
    endtask

    // One sound: a run of samples opened by the first-sample flag. Some runs
    // drop the opening flag or raise it midway, as noise.
    task automatic play_sound(input int len, input int style);
        sample_t smp;
        logic    first;
        int      walk;
        int      v;
        bit      broken;
        walk   = int'($urandom_range(0, 20000)) - 10000;
        broken = ($urandom_range(0, 99) < 6);
        for (int k = 0; k < len; k++)
        begin
            case (style)
                0: smp = sample_t'($urandom());
                1: smp = sample_t'(int'($urandom_range(0, 600)) - 300);
                2:
                begin
                    v   = $urandom_range(0, 767);
                    smp = $urandom_range(0, 1) ? sample_t'(32767 - v) : sample_t'(-32768 + v);
                end
                default:
                begin
                    walk = walk + int'($urandom_range(0, 4000)) - 2000;
                    if (walk > 32767)
                    begin
                        walk = 32767;
                    end
                    else if (walk < -32768)
                    begin
                        walk = -32768;
                    end
                    smp = sample_t'(walk);
                end
            endcase
            first = (k == 0) ? !broken : ($urandom_range(0, 99) < 3);
            offer_sample(smp, first);
        end
    endtask

    // Sample source: directed cases first, then random sounds.
    initial
    begin
        int len;
        @(posedge rst_n);
        @(negedge clk);

        // zero, the extremes and the error they leave behind
        offer_sample(16'sd0, 1'b1);
        offer_sample(16'sd32767, 1'b1);
        offer_sample(16'sd32767, 1'b0);     // positive error pushes the sum past full scale
        offer_sample(16'sd32767, 1'b0);
        offer_sample(-16'sd32768, 1'b1);    // most negative sample shares a code with -32767
        offer_sample(-16'sd32768, 1'b0);    // negative error pushes the sum below full scale
        offer_sample(-16'sd32767, 1'b1);
        offer_sample(-16'sd1, 1'b1);        // the code that expands to minus one
        offer_sample(-16'sd1, 1'b0);
        offer_sample(16'sd1, 1'b0);
        offer_sample(16'sd0, 1'b0);
        offer_sample(-16'sd5, 1'b1);
        offer_sample(16'sd100, 1'b0);
        offer_sample(-16'sd100, 1'b0);
        offer_sample(16'sd1000, 1'b0);
        offer_sample(-16'sd1000, 1'b0);
        offer_sample(16'sd8000, 1'b0);
        offer_sample(-16'sd8000, 1'b0);
        offer_sample(16'sd16000, 1'b0);
        offer_sample(-16'sd16000, 1'b0);
        offer_sample(16'sd31000, 1'b0);     // largest step of the top segment
        offer_sample(-16'sd31000, 1'b0);
        offer_sample(16'sh5555, 1'b1);
        offer_sample(16'shaaaa, 1'b0);

        while (samples_sent < SAMPLE_TARGET)
        begin
            idle_on = ($urandom_range(0, 99) < 75);
            // Stall the output side once, long enough to fill the block.
            if (!hold_done && samples_sent >= 700)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
            play_sound(len, $urandom_range(0, 3));
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        // Drain: wait for every predicted code, then a settling wait before the verdict.
        while (codes_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Output side: steady accept when idling is off, random stalls when on,
    // and one long hold-off counted here in cycles.
    initial
    begin
        hold_left  = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left  = hold_left - 1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                m_tready    <= 1'b0;
            end
            else if (!idle_on)
            begin
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left  = stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Safety net against a hung block.
    initial
    begin
        #12000000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mlef_pkg.sv
hw/rtl/mlef_quant.sv
hw/rtl/mulaw_error_feedback_encoder_core.sv
tb/mulaw_error_feedback_encoder_checker.sv
tb/mulaw_error_feedback_encoder_core_tb.sv
